// File: hdl/rkpd_pkg.sv
// Package for the RK4 projectile step pipeline: widths, latencies, codes,
// the pipeline context word and the saturating helper. No dependencies.
package rkpd_pkg;

    localparam int DW            = 48;          // state value width
    localparam int MW            = DW + 3;      // multiplier operand width
    localparam int SW            = DW + 3;      // exact weighted-sum width
    localparam int ADD_W         = DW + 4;      // width of sums before clamping
    localparam int GRAV_W        = 39;
    localparam int DRAG_W        = 37;
    localparam int STEP_W        = 32;
    localparam int STEP_FRAC     = 32;
    localparam int FRAC_BITS_DEF = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = GRAV_W;

    localparam int MUL_LAT       = 4;
    localparam int SQRT_LAT      = DW + 4;
    localparam int RK_STAGES     = 4;

    localparam int          GRAVITY_INT = 10;
    localparam int          DRAG_INT    = 1;
    localparam logic [STEP_W-1:0] STEP_RST  = 32'd42950;
    localparam logic [31:0]       ONE_SIXTH = 32'h2AAA_AAAB;

    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP    = 2'd2;

    localparam logic signed [ADD_W-1:0] SAT_HI = {{(ADD_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [ADD_W-1:0] SAT_LO = {{(ADD_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

    // Everything one item carries down the pipeline.
    typedef struct packed {
        logic signed [DW-1:0] t;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] vx;
        logic signed [DW-1:0] vy;
        logic signed [DW-1:0] sx;
        logic signed [DW-1:0] sy;
        logic signed [DW-1:0] ax;
        logic signed [DW-1:0] ay;
        logic signed [SW-1:0] skx;
        logic signed [SW-1:0] sky;
        logic signed [SW-1:0] skvx;
        logic signed [SW-1:0] skvy;
        logic                 sat;
    } t_ctx;

    typedef struct packed {
        logic                 sat;
        logic signed [DW-1:0] v;
    } t_satv;

    // Clamp a wide signed sum into the state range and flag the clamp.
    function automatic t_satv sat_dw(input logic signed [ADD_W-1:0] a);
        t_satv r;
        r.sat = 1'b0;
        r.v   = a[DW-1:0];
        if (a > SAT_HI) begin
            r.sat = 1'b1;
            r.v   = SAT_HI[DW-1:0];
        end else if (a < SAT_LO) begin
            r.sat = 1'b1;
            r.v   = SAT_LO[DW-1:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/rkpd_mul.sv
// Pipelined signed multiply, shift right toward zero and clamp to the state range.
// Depends on rkpd_pkg.
module rkpd_mul #(
    parameter int SH = rkpd_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic signed [rkpd_pkg::MW-1:0]    i_a,
    input  logic signed [rkpd_pkg::MW-1:0]    i_b,
    output logic signed [rkpd_pkg::DW-1:0]    o_p,
    output logic                              o_sat
);
    import rkpd_pkg::*;

    localparam int LO_W = (MW + 1) / 2;
    localparam int HI_W = MW - LO_W;
    localparam int PW   = 2 * MW;

    logic [MW-1:0]        r_ma, r_mb;
    logic                 r_neg1, r_neg2, r_neg3;
    logic [2*LO_W-1:0]    r_p00;
    logic [LO_W+HI_W-1:0] r_p01, r_p10;
    logic [2*HI_W-1:0]    r_p11;
    logic [PW-1:0]        r_prod;
    logic [PW-1:0]        sh;
    logic                 ovf;

    // Stage 1: magnitudes and the sign of the product.
    always_ff @(posedge i_clk) begin
        r_neg1 <= i_a[MW-1] ^ i_b[MW-1];
        r_ma   <= i_a[MW-1] ? MW'(-i_a) : MW'(i_a);
        r_mb   <= i_b[MW-1] ? MW'(-i_b) : MW'(i_b);
    end

    // Stage 2: four partial products of at most 26 by 26 bits.
    always_ff @(posedge i_clk) begin
        r_neg2 <= r_neg1;
        r_p00  <= r_ma[LO_W-1:0] * r_mb[LO_W-1:0];
        r_p01  <= r_ma[LO_W-1:0] * r_mb[MW-1:LO_W];
        r_p10  <= r_ma[MW-1:LO_W] * r_mb[LO_W-1:0];
        r_p11  <= r_ma[MW-1:LO_W] * r_mb[MW-1:LO_W];
    end

    // Stage 3: the exact product.
    always_ff @(posedge i_clk) begin
        r_neg3 <= r_neg2;
        r_prod <= PW'(r_p00) + (PW'(r_p01) << LO_W) + (PW'(r_p10) << LO_W)
                + (PW'(r_p11) << (2 * LO_W));
    end

    assign sh  = r_prod >> SH;
    assign ovf = r_neg3 ? ((|sh[PW-1:DW]) | (sh[DW-1] & (|sh[DW-2:0])))
                        : (|sh[PW-1:DW-1]);

    // Stage 4: sign, clamp and flag.
    always_ff @(posedge i_clk) begin
        o_sat <= ovf;
        if (ovf) begin
            o_p <= r_neg3 ? SAT_LO[DW-1:0] : SAT_HI[DW-1:0];
        end else begin
            o_p <= r_neg3 ? -sh[DW-1:0] : sh[DW-1:0];
        end
    end

endmodule

// File: hdl/rkpd_sqrt.sv
// Pipelined speed unit: squares both velocity parts and takes the floor square
// root one bit per stage, clamped to the state range. Depends on rkpd_pkg.
module rkpd_sqrt (
    input  logic                              i_clk,
    input  logic signed [rkpd_pkg::DW-1:0]    i_vx,
    input  logic signed [rkpd_pkg::DW-1:0]    i_vy,
    output logic        [rkpd_pkg::DW-1:0]    o_root,
    output logic                              o_sat
);
    import rkpd_pkg::*;

    localparam int HW    = DW / 2;
    localparam int RAD_W = 2 * DW;
    localparam int REM_W = DW + 4;

    logic [DW-1:0]    r_mx, r_my;
    logic [2*HW-1:0]  r_xll, r_xlh, r_xhh, r_yll, r_ylh, r_yhh;
    logic [RAD_W-1:0] r_rad;
    logic [REM_W-1:0] r_rem  [DW];
    logic [DW-1:0]    r_root [DW];
    logic [RAD_W-1:0] r_rsh  [DW];

    always_ff @(posedge i_clk) begin
        r_mx <= i_vx[DW-1] ? DW'(-i_vx) : DW'(i_vx);
        r_my <= i_vy[DW-1] ? DW'(-i_vy) : DW'(i_vy);
    end

    always_ff @(posedge i_clk) begin
        r_xll <= r_mx[HW-1:0]  * r_mx[HW-1:0];
        r_xlh <= r_mx[HW-1:0]  * r_mx[DW-1:HW];
        r_xhh <= r_mx[DW-1:HW] * r_mx[DW-1:HW];
        r_yll <= r_my[HW-1:0]  * r_my[HW-1:0];
        r_ylh <= r_my[HW-1:0]  * r_my[DW-1:HW];
        r_yhh <= r_my[DW-1:HW] * r_my[DW-1:HW];
    end

    always_ff @(posedge i_clk) begin
        r_rad <= RAD_W'(r_xll) + (RAD_W'(r_xlh) << (HW + 1)) + (RAD_W'(r_xhh) << DW)
               + RAD_W'(r_yll) + (RAD_W'(r_ylh) << (HW + 1)) + (RAD_W'(r_yhh) << DW);
    end

    // Restoring digit recurrence: two radicand bits in, one root bit out per stage.
    for (genvar j = 0; j < DW; j++) begin : g_bit
        logic [REM_W-1:0] rem_in, rem_t, trial;
        logic [DW-1:0]    root_in;
        logic [RAD_W-1:0] rad_in;
        logic             ge;

        if (j == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = r_rad;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
            assign rad_in  = r_rsh[j-1];
        end

        assign rem_t = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial = {{(REM_W-DW-2){1'b0}}, root_in, 2'b01};
        assign ge    = rem_t >= trial;

        always_ff @(posedge i_clk) begin
            r_rem[j]  <= ge ? rem_t - trial : rem_t;
            r_root[j] <= {root_in[DW-2:0], ge};
            r_rsh[j]  <= {rad_in[RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        o_sat  <= r_root[DW-1][DW-1];
        o_root <= r_root[DW-1][DW-1] ? SAT_HI[DW-1:0] : r_root[DW-1];
    end

endmodule

// File: hdl/rk4_projectile_drag_step.sv
// Top level of the RK4 projectile step with quadratic drag.
// Depends on rkpd_pkg, rkpd_mul and rkpd_sqrt.
//
// This block advances one projectile state (time, position, velocity, all
// signed fixed point with FRAC_BITS fraction bits) by one classical
// fourth-order Runge-Kutta step under gravity and quadratic drag. It is a
// fully pipelined datapath: a new word is accepted on every clock cycle at
// which i_start is high, o_busy is always low, and each accepted word comes
// back exactly once, in order, as one cycle of o_done after a fixed latency.
// The receiver cannot stall the block, so results must be taken when o_done
// is high. The latency is set by the speed unit, which resolves one root
// bit per stage for each of the four slope evaluations, and by the
// four-stage multipliers (partial products of at most 26 by 26 bits). The
// configuration registers (gravity, drag ratio, step size) are read by every
// stage in flight, so write them only while no word is in the pipeline.
module rk4_projectile_drag_step #(
    parameter int FRAC_BITS = rkpd_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    output logic                                   o_busy,
    input  logic signed [rkpd_pkg::DW-1:0]         i_time_in,
    input  logic signed [rkpd_pkg::DW-1:0]         i_pos_x_in,
    input  logic signed [rkpd_pkg::DW-1:0]         i_pos_y_in,
    input  logic signed [rkpd_pkg::DW-1:0]         i_vel_x_in,
    input  logic signed [rkpd_pkg::DW-1:0]         i_vel_y_in,
    input  logic                                   i_cfg_we,
    input  logic        [rkpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [rkpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                   o_done,
    output logic signed [rkpd_pkg::DW-1:0]         o_time_out,
    output logic signed [rkpd_pkg::DW-1:0]         o_pos_x_out,
    output logic signed [rkpd_pkg::DW-1:0]         o_pos_y_out,
    output logic signed [rkpd_pkg::DW-1:0]         o_vel_x_out,
    output logic signed [rkpd_pkg::DW-1:0]         o_vel_y_out,
    output logic                                   o_landed,
    output logic                                   o_saturated
);
    import rkpd_pkg::*;

    localparam logic [GRAV_W-1:0] GRAV_RST = GRAV_W'(64'(GRAVITY_INT) << FRAC_BITS);
    localparam logic [DRAG_W-1:0] DRAG_RST = DRAG_W'(64'(DRAG_INT) << FRAC_BITS);

    // Configuration registers.
    logic [GRAV_W-1:0] r_grav;
    logic [DRAG_W-1:0] r_drag;
    logic [STEP_W-1:0] r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= GRAV_RST;
            r_drag <= DRAG_RST;
            r_step <= STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GRAVITY: r_grav <= i_cfg_data[GRAV_W-1:0];
                REG_DRAG:    r_drag <= i_cfg_data[DRAG_W-1:0];
                REG_STEP:    r_step <= i_cfg_data[STEP_W-1:0];
                default:     ;
            endcase
        end
    end

    // The pipeline never holds anything off.
    assign o_busy = 1'b0;

    // Context and valid bit at the entry of each slope stage; the last entry
    // feeds the weighted-mean section.
    t_ctx             stage_ctx [RK_STAGES+1];
    logic [RK_STAGES:0] stage_vld;

    always_comb begin
        stage_ctx[0]      = '0;
        stage_ctx[0].t    = i_time_in;
        stage_ctx[0].x    = i_pos_x_in;
        stage_ctx[0].y    = i_pos_y_in;
        stage_ctx[0].vx   = i_vel_x_in;
        stage_ctx[0].vy   = i_vel_y_in;
        stage_ctx[0].sx   = i_vel_x_in;
        stage_ctx[0].sy   = i_vel_y_in;
    end
    assign stage_vld[0] = i_start & ~o_busy;

    // One slope evaluation per stage: speed, drag factor, acceleration, and
    // for the first three stages the velocity probe for the next one.
    for (genvar g = 0; g < RK_STAGES; g++) begin : g_rk
        localparam bit DOUBLE = (g == 1) || (g == 2);

        logic [DW-1:0]        root;
        logic                 sq_sat;
        logic signed [DW-1:0] d, px, py;
        logic                 d_sat, px_sat, py_sat;
        t_ctx                 r_ca [SQRT_LAT];
        t_ctx                 r_cb [MUL_LAT];
        t_ctx                 r_cc [MUL_LAT];
        logic [SQRT_LAT-1:0]  r_va;
        logic [MUL_LAT-1:0]   r_vb, r_vc;
        t_ctx                 ctx_b, ctx_c, n_e1, n_e2;
        t_ctx                 r_e1, r_e2;
        logic                 r_ve1, r_ve2;
        t_satv                ax_s, ay_s;

        rkpd_sqrt u_sqrt (
            .i_clk  (i_clk),
            .i_vx   (stage_ctx[g].sx),
            .i_vy   (stage_ctx[g].sy),
            .o_root (root),
            .o_sat  (sq_sat)
        );

        always_ff @(posedge i_clk) begin
            r_ca[0] <= stage_ctx[g];
            for (int k = 1; k < SQRT_LAT; k++) begin
                r_ca[k] <= r_ca[k-1];
            end
            r_cb[0] <= ctx_b;
            r_cc[0] <= ctx_c;
            for (int k = 1; k < MUL_LAT; k++) begin
                r_cb[k] <= r_cb[k-1];
                r_cc[k] <= r_cc[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_va <= '0;
                r_vb <= '0;
                r_vc <= '0;
            end else begin
                r_va <= {r_va[SQRT_LAT-2:0], stage_vld[g]};
                r_vb <= {r_vb[MUL_LAT-2:0], r_va[SQRT_LAT-1]};
                r_vc <= {r_vc[MUL_LAT-2:0], r_vb[MUL_LAT-1]};
            end
        end

        always_comb begin
            ctx_b     = r_ca[SQRT_LAT-1];
            ctx_b.sat = ctx_b.sat | sq_sat;
            ctx_c     = r_cb[MUL_LAT-1];
            ctx_c.sat = ctx_c.sat | d_sat;
        end

        // Drag factor k*|v|.
        rkpd_mul #(.SH(FRAC_BITS)) u_mul_d (
            .i_clk (i_clk),
            .i_a   (MW'(r_drag)),
            .i_b   (MW'(root)),
            .o_p   (d),
            .o_sat (d_sat)
        );

        rkpd_mul #(.SH(FRAC_BITS)) u_mul_ax (
            .i_clk (i_clk),
            .i_a   (MW'(d)),
            .i_b   (MW'(ctx_c.sx)),
            .o_p   (px),
            .o_sat (px_sat)
        );

        rkpd_mul #(.SH(FRAC_BITS)) u_mul_ay (
            .i_clk (i_clk),
            .i_a   (MW'(d)),
            .i_b   (MW'(ctx_c.sy)),
            .o_p   (py),
            .o_sat (py_sat)
        );

        // Acceleration, and the position slopes folded into their sums.
        always_comb begin
            n_e1 = r_cc[MUL_LAT-1];
            ax_s = sat_dw(-ADD_W'(px));
            ay_s = sat_dw(-ADD_W'({1'b0, r_grav}) - ADD_W'(py));
            n_e1.ax  = ax_s.v;
            n_e1.ay  = ay_s.v;
            n_e1.skx = n_e1.skx + (DOUBLE ? SW'(n_e1.sx) <<< 1 : SW'(n_e1.sx));
            n_e1.sky = n_e1.sky + (DOUBLE ? SW'(n_e1.sy) <<< 1 : SW'(n_e1.sy));
            n_e1.sat = n_e1.sat | px_sat | py_sat | ax_s.sat | ay_s.sat;
        end

        // Velocity slopes folded into their sums.
        always_comb begin
            n_e2      = r_e1;
            n_e2.skvx = r_e1.skvx + (DOUBLE ? SW'(r_e1.ax) <<< 1 : SW'(r_e1.ax));
            n_e2.skvy = r_e1.skvy + (DOUBLE ? SW'(r_e1.ay) <<< 1 : SW'(r_e1.ay));
        end

        always_ff @(posedge i_clk) begin
            r_e1 <= n_e1;
            r_e2 <= n_e2;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ve1 <= 1'b0;
                r_ve2 <= 1'b0;
            end else begin
                r_ve1 <= r_vc[MUL_LAT-1];
                r_ve2 <= r_ve1;
            end
        end

        if (g < RK_STAGES - 1) begin : g_probe
            // The first two probes use half a step, the third a full step.
            localparam int USH = (g < 2) ? STEP_FRAC + 1 : STEP_FRAC;

            logic signed [DW-1:0] ux, uy;
            logic                 ux_sat, uy_sat;
            t_ctx                 r_cd [MUL_LAT];
            logic [MUL_LAT-1:0]   r_vd;
            t_ctx                 n_f, r_f;
            logic                 r_vf;
            t_satv                sx_s, sy_s;

            rkpd_mul #(.SH(USH)) u_mul_ux (
                .i_clk (i_clk),
                .i_a   (MW'(r_step)),
                .i_b   (MW'(r_e2.ax)),
                .o_p   (ux),
                .o_sat (ux_sat)
            );

            rkpd_mul #(.SH(USH)) u_mul_uy (
                .i_clk (i_clk),
                .i_a   (MW'(r_step)),
                .i_b   (MW'(r_e2.ay)),
                .o_p   (uy),
                .o_sat (uy_sat)
            );

            always_ff @(posedge i_clk) begin
                r_cd[0] <= r_e2;
                for (int k = 1; k < MUL_LAT; k++) begin
                    r_cd[k] <= r_cd[k-1];
                end
                r_f <= n_f;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vd <= '0;
                    r_vf <= 1'b0;
                end else begin
                    r_vd <= {r_vd[MUL_LAT-2:0], r_ve2};
                    r_vf <= r_vd[MUL_LAT-1];
                end
            end

            always_comb begin
                n_f     = r_cd[MUL_LAT-1];
                sx_s    = sat_dw(ADD_W'(n_f.vx) + ADD_W'(ux));
                sy_s    = sat_dw(ADD_W'(n_f.vy) + ADD_W'(uy));
                n_f.sx  = sx_s.v;
                n_f.sy  = sy_s.v;
                n_f.sat = n_f.sat | ux_sat | uy_sat | sx_s.sat | sy_s.sat;
            end

            assign stage_ctx[g+1] = r_f;
            assign stage_vld[g+1] = r_vf;
        end else begin : g_last
            assign stage_ctx[g+1] = r_e2;
            assign stage_vld[g+1] = r_ve2;
        end
    end

    // Weighted mean: each sum times one sixth, then times the step, then
    // added to the old state.
    logic signed [MW-1:0] msum [4];
    logic signed [DW-1:0] mq   [4];
    logic signed [DW-1:0] mp   [4];
    logic signed [DW-1:0] mbase[4];
    logic [3:0]           mq_sat, mp_sat;
    t_ctx                 r_ch [MUL_LAT];
    t_ctx                 r_ci [MUL_LAT];
    logic [MUL_LAT-1:0]   r_vh, r_vi;
    t_ctx                 ctx_i, ctx_o;
    logic signed [ADD_W-1:0] hf;

    assign msum[0] = MW'(stage_ctx[RK_STAGES].skx);
    assign msum[1] = MW'(stage_ctx[RK_STAGES].sky);
    assign msum[2] = MW'(stage_ctx[RK_STAGES].skvx);
    assign msum[3] = MW'(stage_ctx[RK_STAGES].skvy);

    always_comb begin
        ctx_i     = r_ch[MUL_LAT-1];
        ctx_i.sat = ctx_i.sat | (|mq_sat);
    end

    assign ctx_o    = r_ci[MUL_LAT-1];
    assign mbase[0] = ctx_o.x;
    assign mbase[1] = ctx_o.y;
    assign mbase[2] = ctx_o.vx;
    assign mbase[3] = ctx_o.vy;

    for (genvar m = 0; m < 4; m++) begin : g_mean
        rkpd_mul #(.SH(32)) u_mul_sixth (
            .i_clk (i_clk),
            .i_a   (msum[m]),
            .i_b   (MW'(ONE_SIXTH)),
            .o_p   (mq[m]),
            .o_sat (mq_sat[m])
        );

        rkpd_mul #(.SH(STEP_FRAC)) u_mul_step (
            .i_clk (i_clk),
            .i_a   (MW'(r_step)),
            .i_b   (MW'(mq[m])),
            .o_p   (mp[m]),
            .o_sat (mp_sat[m])
        );
    end

    always_ff @(posedge i_clk) begin
        r_ch[0] <= stage_ctx[RK_STAGES];
        r_ci[0] <= ctx_i;
        for (int k = 1; k < MUL_LAT; k++) begin
            r_ch[k] <= r_ch[k-1];
            r_ci[k] <= r_ci[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vh <= '0;
            r_vi <= '0;
        end else begin
            r_vh <= {r_vh[MUL_LAT-2:0], stage_vld[RK_STAGES]};
            r_vi <= {r_vi[MUL_LAT-2:0], r_vh[MUL_LAT-1]};
        end
    end

    // The step size is Q0.32; bring it to the state's fraction width.
    if (FRAC_BITS >= STEP_FRAC) begin : g_hf_up
        assign hf = ADD_W'(r_step) << (FRAC_BITS - STEP_FRAC);
    end else begin : g_hf_down
        assign hf = ADD_W'(r_step >> (STEP_FRAC - FRAC_BITS));
    end

    // Output register: final sums, clamps and flags.
    t_satv n_t, n_x, n_y, n_vx, n_vy;
    logic  n_sat;
    logic  r_done;
    logic signed [DW-1:0] r_t, r_x, r_y, r_vx, r_vy;
    logic  r_landed, r_sat;

    always_comb begin
        n_t   = sat_dw(ADD_W'(ctx_o.t) + hf);
        n_x   = sat_dw(ADD_W'(mbase[0]) + ADD_W'(mp[0]));
        n_y   = sat_dw(ADD_W'(mbase[1]) + ADD_W'(mp[1]));
        n_vx  = sat_dw(ADD_W'(mbase[2]) + ADD_W'(mp[2]));
        n_vy  = sat_dw(ADD_W'(mbase[3]) + ADD_W'(mp[3]));
        n_sat = ctx_o.sat | (|mp_sat) | n_t.sat | n_x.sat | n_y.sat | n_vx.sat | n_vy.sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vi[MUL_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_t      <= n_t.v;
        r_x      <= n_x.v;
        r_y      <= n_y.v;
        r_vx     <= n_vx.v;
        r_vy     <= n_vy.v;
        r_landed <= n_y.v[DW-1];
        r_sat    <= n_sat;
    end

    assign o_done      = r_done;
    assign o_time_out  = r_t;
    assign o_pos_x_out = r_x;
    assign o_pos_y_out = r_y;
    assign o_vel_x_out = r_vx;
    assign o_vel_y_out = r_vy;
    assign o_landed    = r_landed;
    assign o_saturated = r_sat;

endmodule
